### src/knps_pkg.sv
// ----------------------------------------------------------------------------
// knps_pkg - shared types and constants
// Widths, configuration register indexes and the structs passed between the
// distance pipeline, the sort cells and the top level.
// ----------------------------------------------------------------------------
package knps_pkg;

    localparam int NEIGHBOR_COUNT = 5;
    localparam int CNT_W          = $clog2(NEIGHBOR_COUNT + 1);

    localparam int ID_W      = 32;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y  = 2'd2;

    // candidate leaving the distance pipeline
    typedef struct packed {
        logic              valid;
        logic              skip;
        logic              last;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dist_sq;
    } t_cand;

    // what a sort cell shows its right-hand neighbor
    typedef struct packed {
        logic              take;
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dist_sq;
    } t_cell_link;

endpackage

### src/knps_cfg_if.sv
// ----------------------------------------------------------------------------
// knps_cfg_if - configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface knps_cfg_if;
    import knps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/knps_point_if.sv
// ----------------------------------------------------------------------------
// knps_point_if - candidate point channel
// One point request per handshake: id, coordinates and end-of-set flag.
// ----------------------------------------------------------------------------
interface knps_point_if;
    import knps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ID_W-1:0]           point_id;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      final_point;

    modport source (output valid, output point_id, output point_x, output point_y,
                    output final_point, input ready);
    modport sink   (input valid, input point_id, input point_x, input point_y,
                    input final_point, output ready);
endinterface

### src/knps_result_if.sv
// ----------------------------------------------------------------------------
// knps_result_if - neighbor result channel
// One answer entry per handshake, nearest first.
// ----------------------------------------------------------------------------
interface knps_result_if;
    import knps_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] neighbor_id;
    logic            found;
    logic            last_of_run;

    modport source (output valid, output neighbor_id, output found,
                    output last_of_run, input ready);
    modport sink   (input valid, input neighbor_id, input found,
                    input last_of_run, output ready);
endinterface

### src/knps_dist.sv
// ----------------------------------------------------------------------------
// knps_dist - squared distance pipeline
// Three stages: coordinate differences, squares, sum. Advances on i_en.
// ----------------------------------------------------------------------------
module knps_dist (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [knps_pkg::ID_W-1:0]          i_point_id,
    input  logic signed [knps_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [knps_pkg::COORD_W-1:0] i_point_y,
    input  logic                               i_final_point,
    input  logic [knps_pkg::ID_W-1:0]          i_query_id,
    input  logic signed [knps_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [knps_pkg::COORD_W-1:0] i_query_y,
    output knps_pkg::t_cand                    o_cand
);
    import knps_pkg::*;

    logic                     r_s1_valid, r_s1_skip, r_s1_last;
    logic [ID_W-1:0]          r_s1_id;
    logic signed [DIFF_W-1:0] r_s1_dx, r_s1_dy;

    logic                     r_s2_valid, r_s2_skip, r_s2_last;
    logic [ID_W-1:0]          r_s2_id;
    logic [SQ_W-1:0]          r_s2_sqx, r_s2_sqy;

    logic                     r_s3_valid, r_s3_skip, r_s3_last;
    logic [ID_W-1:0]          r_s3_id;
    logic [DIST_W-1:0]        r_s3_dist;

    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [PROD_W-1:0] prod_x, prod_y;

    assign dx     = DIFF_W'(i_point_x) - DIFF_W'(i_query_x);
    assign dy     = DIFF_W'(i_point_y) - DIFF_W'(i_query_y);
    // squares are below 2^32, upper product bits are always zero
    assign prod_x = r_s1_dx * r_s1_dx;
    assign prod_y = r_s1_dy * r_s1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_skip <= (i_point_id == i_query_id);
            r_s1_last <= i_final_point;
            r_s1_id   <= i_point_id;
            r_s1_dx   <= dx;
            r_s1_dy   <= dy;

            r_s2_skip <= r_s1_skip;
            r_s2_last <= r_s1_last;
            r_s2_id   <= r_s1_id;
            r_s2_sqx  <= prod_x[SQ_W-1:0];
            r_s2_sqy  <= prod_y[SQ_W-1:0];

            r_s3_skip <= r_s2_skip;
            r_s3_last <= r_s2_last;
            r_s3_id   <= r_s2_id;
            r_s3_dist <= {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
        end
    end

    assign o_cand.valid   = r_s3_valid;
    assign o_cand.skip    = r_s3_skip;
    assign o_cand.last    = r_s3_last;
    assign o_cand.id      = r_s3_id;
    assign o_cand.dist_sq = r_s3_dist;

endmodule

### src/knps_cell.sv
// ----------------------------------------------------------------------------
// knps_cell - one entry of the sorted neighbor list
// Takes the candidate, shifts in its left neighbor, or holds.
// ----------------------------------------------------------------------------
module knps_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ins,
    input  logic                           i_clr,
    input  logic [knps_pkg::ID_W-1:0]      i_cand_id,
    input  logic [knps_pkg::DIST_W-1:0]    i_cand_dist,
    input  knps_pkg::t_cell_link           i_prev,
    output knps_pkg::t_cell_link           o_link,
    output logic                           o_next_valid,
    output logic [knps_pkg::ID_W-1:0]      o_next_id
);
    import knps_pkg::*;

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [DIST_W-1:0] r_dist;
    logic              n_valid;
    logic [ID_W-1:0]   n_id;
    logic [DIST_W-1:0] n_dist;
    logic              take;

    // ties go after the kept entry, so only a strictly farther entry yields
    assign take = !r_valid || (r_dist > i_cand_dist);

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_dist  = r_dist;
        if (i_ins) begin
            if (i_prev.take) begin
                n_valid = i_prev.valid;
                n_id    = i_prev.id;
                n_dist  = i_prev.dist_sq;
            end else if (take) begin
                n_valid = 1'b1;
                n_id    = i_cand_id;
                n_dist  = i_cand_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clr) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_dist <= n_dist;
    end

    assign o_link.take    = take;
    assign o_link.valid   = r_valid;
    assign o_link.id      = r_id;
    assign o_link.dist_sq = r_dist;
    assign o_next_valid   = n_valid;
    assign o_next_id      = n_id;

endmodule

### src/knps_outq.sv
// ----------------------------------------------------------------------------
// knps_outq - answer shift register
// Loads a whole answer run at once and shifts it out one entry per request.
// ----------------------------------------------------------------------------
module knps_outq (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_load,
    input  logic [knps_pkg::CNT_W-1:0]                        i_load_cnt,
    input  logic [knps_pkg::NEIGHBOR_COUNT-1:0][knps_pkg::ID_W-1:0] i_load_ids,
    output logic                                              o_busy,
    knps_result_if.source                                     o_result
);
    import knps_pkg::*;

    logic [CNT_W-1:0]                     r_cnt, n_cnt;
    logic                                 r_none, n_none;
    logic [NEIGHBOR_COUNT-1:0][ID_W-1:0]  r_ids, n_ids;
    logic                                 pop;

    assign pop = o_result.valid && o_result.ready;

    always_comb begin
        n_cnt  = r_cnt;
        n_none = r_none;
        n_ids  = r_ids;
        if (i_load) begin
            if (i_load_cnt == '0) begin
                // empty list: a single not-found entry
                n_cnt  = CNT_W'(1);
                n_none = 1'b1;
                n_ids  = '0;
            end else begin
                n_cnt  = i_load_cnt;
                n_none = 1'b0;
                n_ids  = i_load_ids;
            end
        end else if (pop) begin
            n_cnt = r_cnt - CNT_W'(1);
            for (int i = 0; i < NEIGHBOR_COUNT - 1; i++) begin
                n_ids[i] = r_ids[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_none <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_none <= n_none;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ids <= n_ids;
    end

    assign o_busy               = (r_cnt != '0);
    assign o_result.valid       = (r_cnt != '0);
    assign o_result.neighbor_id = r_ids[0];
    assign o_result.found       = !r_none;
    assign o_result.last_of_run = (r_cnt == CNT_W'(1));

endmodule

### src/k_nearest_point_select_unit.sv
// ----------------------------------------------------------------------------
// k_nearest_point_select_unit - streaming top-K nearest neighbor selector
// Keeps the NEIGHBOR_COUNT points closest to a query point, sorted by
// squared distance, and emits their ids when a set ends.
//
// Usage:
//   i_cfg    : write query_id (0), query_x (1), query_y (2) while idle.
//              Always ready.
//   i_point  : one point request per cycle while ready; final_point
//              closes the set. Points with the query id are dropped.
//   o_result : on a closed set, the kept ids nearest first (found = 1),
//              or one entry with found = 0 if nothing was kept.
//              last_of_run marks the last entry of the run.
// Timing:
//   A point passes the difference, square and sum stages of the distance
//   pipeline, then updates the cell row; the first result of a run is
//   valid in the cycle after. Throughput is one point per cycle while
//   i_point is ready; the cell row compares and shifts at once. A final
//   point stalls i_point at the cell row while the previous run drains.
// Reset: clears the list, the answer buffer and the query registers.
// A stalled receiver holds o_result steady; the list keeps filling until a
// final point needs the answer buffer.
// ----------------------------------------------------------------------------
module k_nearest_point_select_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    knps_cfg_if.sink       i_cfg,
    knps_point_if.sink     i_point,
    knps_result_if.source  o_result
);
    import knps_pkg::*;

    logic [ID_W-1:0]                      r_query_id;
    logic signed [COORD_W-1:0]            r_query_x;
    logic signed [COORD_W-1:0]            r_query_y;

    t_cand                                cand;
    logic                                 en;
    logic                                 ins;
    logic                                 load;
    logic                                 busy;
    t_cell_link                           link [NEIGHBOR_COUNT+1];
    logic [NEIGHBOR_COUNT-1:0]            cell_valid;
    logic [NEIGHBOR_COUNT-1:0]            next_valid;
    logic [NEIGHBOR_COUNT-1:0][ID_W-1:0]  next_ids;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_id <= '0;
            r_query_x  <= '0;
            r_query_y  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_QUERY_ID: r_query_id <= i_cfg.data;
                CFG_QUERY_X:  r_query_x  <= i_cfg.data[COORD_W-1:0];
                CFG_QUERY_Y:  r_query_y  <= i_cfg.data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // a final point cannot hand its run over until the buffer is empty
    assign en            = !(cand.valid && cand.last && busy);
    assign i_point.ready = en;
    assign ins           = en && cand.valid && !cand.skip;
    assign load          = en && cand.valid && cand.last;

    knps_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_point.valid),
        .i_point_id    (i_point.point_id),
        .i_point_x     (i_point.point_x),
        .i_point_y     (i_point.point_y),
        .i_final_point (i_point.final_point),
        .i_query_id    (r_query_id),
        .i_query_x     (r_query_x),
        .i_query_y     (r_query_y),
        .o_cand        (cand)
    );

    // left end of the row never shifts anything in
    assign link[0] = '0;

    for (genvar g = 0; g < NEIGHBOR_COUNT; g++) begin : g_cell
        knps_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ins        (ins),
            .i_clr        (load),
            .i_cand_id    (cand.id),
            .i_cand_dist  (cand.dist_sq),
            .i_prev       (link[g]),
            .o_link       (link[g+1]),
            .o_next_valid (next_valid[g]),
            .o_next_id    (next_ids[g])
        );
        assign cell_valid[g] = link[g+1].valid;
    end

    knps_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_load_cnt (CNT_W'($countones(next_valid))),
        .i_load_ids (next_ids),
        .o_busy     (busy),
        .o_result   (o_result)
    );

    // list stays packed to the left and sorted by distance
    for (genvar g = 0; g < NEIGHBOR_COUNT - 1; g++) begin : g_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            link[g+2].valid |->
                link[g+1].valid && (link[g+1].dist_sq <= link[g+2].dist_sq))
            else $error("cell list not packed or not sorted");
    end

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_point.ready |-> o_result.valid)
        else $error("point channel stalled with no answer pending");

    a_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (cell_valid == '0) && o_result.valid)
        else $error("answer run not handed over or list not cleared");

    a_skip_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && cand.valid && cand.skip && !cand.last |=> $stable(cell_valid))
        else $error("skipped point changed the list");

endmodule
